### rtl/dga_pkg.sv
// shared types, constants and calendar helpers for the gregorian date arithmetic block
`default_nettype none
package dga_pkg;

  // request codes
  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_SUB  = 2'd1;
  localparam logic [1:0] MODE_DIFF = 2'd2;

  localparam int SerW = 22;

  // day and year counts of whole year blocks, and the serial day number of 9999-12-31
  localparam logic [SerW-1:0] DAYS_400    = 22'd146097;
  localparam logic [SerW-1:0] DAYS_100    = 22'd36524;
  localparam logic [SerW-1:0] DAYS_4      = 22'd1461;
  localparam logic [SerW-1:0] DAYS_1      = 22'd365;
  localparam logic [SerW-1:0] YEARS_400   = 22'd400;
  localparam logic [SerW-1:0] YEARS_100   = 22'd100;
  localparam logic [SerW-1:0] YEARS_4     = 22'd4;
  localparam logic [SerW-1:0] YEARS_1     = 22'd1;
  localparam logic [SerW-1:0] LAST_SERIAL = 22'd3652058;

  localparam logic [13:0] YEAR_MAX = 14'd9999;
  localparam logic [3:0]  MONTH_MAX = 4'd12;

  // one compare-subtract-accumulate step
  typedef struct packed {
    logic [SerW-1:0] rem;
    logic [SerW-1:0] acc;
    logic [SerW-1:0] ks;
    logic [SerW-1:0] ka;
    logic            cap;
  } step_req_t;

  typedef struct packed {
    logic            take;
    logic [SerW-1:0] rem;
    logic [SerW-1:0] acc;
  } step_rsp_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    unique case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic [13:0] clamp_year(input logic [13:0] y);
    logic [13:0] r;
    r = y;
    if (y == 14'd0) r = 14'd1;
    if (y > YEAR_MAX) r = YEAR_MAX;
    return r;
  endfunction

  function automatic logic [3:0] clamp_month(input logic [3:0] m);
    logic [3:0] r;
    r = m;
    if (m == 4'd0) r = 4'd1;
    if (m > MONTH_MAX) r = MONTH_MAX;
    return r;
  endfunction

  function automatic logic [4:0] clamp_day(input logic [4:0] d, input logic [4:0] dim);
    logic [4:0] r;
    r = d;
    if (d == 5'd0) r = 5'd1;
    if (d > dim) r = dim;
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/dga_step_unit.sv
// shared compare-subtract and accumulate unit used for every year block and month step
`default_nettype none
module dga_step_unit (
  input  var dga_pkg::step_req_t req,
  output var dga_pkg::step_rsp_t rsp
);

  logic [dga_pkg::SerW:0] sub;

  // borrow out means remainder is below the step size
  assign sub      = {1'b0, req.rem} - {1'b0, req.ks};
  assign rsp.take = !sub[dga_pkg::SerW] && !req.cap;
  assign rsp.rem  = sub[dga_pkg::SerW-1:0];
  assign rsp.acc  = req.acc + req.ka;

endmodule
`default_nettype wire

### rtl/gregorian_date_arithmetic.sv
// top level of the gregorian date arithmetic block: sequencer, datapath registers, output stage
// each request converts both dates to serial days; add and subtract convert the result back too;
// each conversion walks 400-, 100-, 4- and 1-year blocks and then the months through one shared
// compare-subtract unit, one step a cycle, moving on when a block size is exhausted, then the day
// only one request at a time: a new one is taken only in idle, after the last result is handed on
// a finished result waits in the output register while the next request is taken
// reset: synchronous active-low rst_n idles the sequencer and empties the output register
`default_nettype none
module gregorian_date_arithmetic (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output var  logic        in_tready,
  // mode[1:0] year[15:2] month[19:16] day[24:20] day_count[40:25]
  // other_year[54:41] other_month[58:55] other_day[63:59]
  input  wire logic [63:0] in_tdata,
  // result channel
  output var  logic        out_tvalid,
  input  wire logic        out_tready,
  // res_year[13:0] res_month[17:14] res_day[22:18] day_difference[44:23]
  // is_less[45] is_equal[46] is_greater[47] overflow[48] zero pad[55:49]
  output var  logic [55:0] out_tdata
);

  localparam int SW = dga_pkg::SerW;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CONV_A = 3'd1;  // first date to serial day number
  localparam logic [2:0] S_CONV_B = 3'd2;  // second date to serial day number
  localparam logic [2:0] S_CMP    = 3'd3;  // compare flags and distance
  localparam logic [2:0] S_ARITH  = 3'd4;  // add or subtract with saturation
  localparam logic [2:0] S_CONV_R = 3'd5;  // serial day number back to a date
  localparam logic [2:0] S_DONE   = 3'd6;  // hand result to output register

  // conversion phases
  localparam logic [2:0] PH_400 = 3'd0;
  localparam logic [2:0] PH_100 = 3'd1;
  localparam logic [2:0] PH_4   = 3'd2;
  localparam logic [2:0] PH_1   = 3'd3;
  localparam logic [2:0] PH_MON = 3'd4;
  localparam logic [2:0] PH_DAY = 3'd5;

  // control state
  logic [2:0]  state_r, state_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [3:0]  k_r, k_nxt;
  logic        out_valid_r, out_valid_nxt;

  // datapath
  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] acc_r, acc_nxt;
  logic [1:0]    q100_r, q100_nxt;
  logic [4:0]    q4_r, q4_nxt;
  logic [1:0]    q1_r, q1_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [13:0]   y2_r, y2_nxt;
  logic [3:0]    m1_r, m1_nxt, m2_r, m2_nxt;
  logic [4:0]    d1_r, d1_nxt, d2_r, d2_nxt;
  logic [15:0]   dcnt_r, dcnt_nxt;
  logic [SW-1:0] s1_r, s1_nxt, s2_r, s2_nxt;
  logic [13:0]   ry_r, ry_nxt;
  logic [3:0]    rm_r, rm_nxt;
  logic [4:0]    rd_r, rd_nxt;
  logic [SW-1:0] diff_r, diff_nxt;
  logic          lt_r, lt_nxt, eq_r, eq_nxt, gt_r, gt_nxt, ovf_r, ovf_nxt;
  logic [55:0]   out_data_r, out_data_nxt;

  // input fields
  logic [1:0]  in_mode;
  logic [13:0] in_year, in_other_year;
  logic [3:0]  in_month, in_other_month;
  logic [4:0]  in_day, in_other_day;
  logic [15:0] in_day_count;
  logic [13:0] y1_clamped;

  assign in_mode        = in_tdata[1:0];
  assign in_year        = in_tdata[15:2];
  assign in_month       = in_tdata[19:16];
  assign in_day         = in_tdata[24:20];
  assign in_day_count   = in_tdata[40:25];
  assign in_other_year  = in_tdata[54:41];
  assign in_other_month = in_tdata[58:55];
  assign in_other_day   = in_tdata[63:59];
  assign y1_clamped     = dga_pkg::clamp_year(in_year);

  // shared step unit
  dga_pkg::step_req_t step_req;
  dga_pkg::step_rsp_t step_rsp;

  dga_step_unit u_step (
    .req (step_req),
    .rsp (step_rsp)
  );

  // date to serial walks years in the remainder and days in the accumulator,
  // serial to date does the opposite
  logic          to_serial;
  logic [3:0]    cur_m;
  logic [4:0]    cur_d;
  logic          leap;
  logic [4:0]    dim_k;
  logic [4:0]    dim_m;
  logic [4:0]    day_cl;
  logic [SW-1:0] serial;
  logic [SW:0]   cmp_sub;
  logic [SW-1:0] abs_diff;
  logic [SW:0]   add_sum;
  logic [SW:0]   sub_res;

  assign to_serial = (state_r != S_CONV_R);
  assign cur_m     = (state_r == S_CONV_B) ? m2_r : m1_r;
  assign cur_d     = (state_r == S_CONV_B) ? d2_r : d1_r;

  // leap year from the block counts: last year of a 4-year block, and
  // not a century year unless it closes a 400-year block
  assign leap   = (q1_r == 2'd3) && ((q4_r != 5'd24) || (q100_r == 2'd3));
  assign dim_k  = dga_pkg::month_days(k_r, leap);
  assign dim_m  = dga_pkg::month_days(cur_m, leap);
  assign day_cl = dga_pkg::clamp_day(cur_d, dim_m);
  assign serial = acc_r + {{(SW-5){1'b0}}, day_cl} - {{(SW-1){1'b0}}, 1'b1};

  assign cmp_sub  = {1'b0, s1_r} - {1'b0, s2_r};
  assign abs_diff = cmp_sub[SW] ? (~cmp_sub[SW-1:0] + {{(SW-1){1'b0}}, 1'b1})
                                : cmp_sub[SW-1:0];
  assign add_sum  = {1'b0, s1_r} + {{(SW-15){1'b0}}, dcnt_r};
  assign sub_res  = {1'b0, s1_r} - {{(SW-15){1'b0}}, dcnt_r};

  // step sizes per phase
  always_comb begin
    step_req.rem = rem_r;
    step_req.acc = acc_r;
    step_req.ks  = '0;
    step_req.ka  = '0;
    step_req.cap = 1'b1;
    unique case (phase_r)
      PH_400: begin
        step_req.ks  = to_serial ? dga_pkg::YEARS_400 : dga_pkg::DAYS_400;
        step_req.ka  = to_serial ? dga_pkg::DAYS_400  : dga_pkg::YEARS_400;
        step_req.cap = 1'b0;
      end
      PH_100: begin
        step_req.ks  = to_serial ? dga_pkg::YEARS_100 : dga_pkg::DAYS_100;
        step_req.ka  = to_serial ? dga_pkg::DAYS_100  : dga_pkg::YEARS_100;
        step_req.cap = (cnt_r == 5'd3);  // a 400-year block holds at most 3 full centuries
      end
      PH_4: begin
        step_req.ks  = to_serial ? dga_pkg::YEARS_4 : dga_pkg::DAYS_4;
        step_req.ka  = to_serial ? dga_pkg::DAYS_4  : dga_pkg::YEARS_4;
        step_req.cap = 1'b0;
      end
      PH_1: begin
        step_req.ks  = to_serial ? dga_pkg::YEARS_1 : dga_pkg::DAYS_1;
        step_req.ka  = to_serial ? dga_pkg::DAYS_1  : dga_pkg::YEARS_1;
        step_req.cap = (cnt_r == 5'd3);  // last day of a leap year stays in year four
      end
      PH_MON: begin
        if (to_serial) begin
          // remainder counts months still to add
          step_req.ks  = {{(SW-1){1'b0}}, 1'b1};
          step_req.ka  = {{(SW-5){1'b0}}, dim_k};
          step_req.cap = 1'b0;
        end else begin
          step_req.ks  = {{(SW-5){1'b0}}, dim_k};
          step_req.ka  = '0;
          step_req.cap = (k_r == dga_pkg::MONTH_MAX);
        end
      end
      default: begin
        step_req.cap = 1'b1;
      end
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    q100_nxt      = q100_r;
    q4_nxt        = q4_r;
    q1_nxt        = q1_r;
    mode_nxt      = mode_r;
    y2_nxt        = y2_r;
    m1_nxt        = m1_r;
    m2_nxt        = m2_r;
    d1_nxt        = d1_r;
    d2_nxt        = d2_r;
    dcnt_nxt      = dcnt_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    ry_nxt        = ry_r;
    rm_nxt        = rm_r;
    rd_nxt        = rd_r;
    diff_nxt      = diff_r;
    lt_nxt        = lt_r;
    eq_nxt        = eq_r;
    gt_nxt        = gt_r;
    ovf_nxt       = ovf_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          // year and month clamp here, day clamps once the leap year is known
          mode_nxt  = in_mode;
          m1_nxt    = dga_pkg::clamp_month(in_month);
          d1_nxt    = in_day;
          dcnt_nxt  = in_day_count;
          y2_nxt    = dga_pkg::clamp_year(in_other_year);
          m2_nxt    = dga_pkg::clamp_month(in_other_month);
          d2_nxt    = in_other_day;
          rem_nxt   = {{(SW-14){1'b0}}, y1_clamped - 14'd1};
          acc_nxt   = '0;
          phase_nxt = PH_400;
          cnt_nxt   = '0;
          state_nxt = S_CONV_A;
        end
      end

      S_CONV_A, S_CONV_B, S_CONV_R: begin
        priority if (phase_r == PH_DAY) begin
          unique case (state_r)
            S_CONV_A: begin
              s1_nxt    = serial;
              rem_nxt   = {{(SW-14){1'b0}}, y2_r - 14'd1};
              acc_nxt   = '0;
              phase_nxt = PH_400;
              cnt_nxt   = '0;
              state_nxt = S_CONV_B;
            end
            S_CONV_B: begin
              s2_nxt    = serial;
              state_nxt = S_CMP;
            end
            default: begin
              ry_nxt    = acc_r[13:0] + 14'd1;
              rm_nxt    = k_r;
              rd_nxt    = rem_r[4:0] + 5'd1;
              state_nxt = S_DONE;
            end
          endcase
        end else if (step_rsp.take) begin
          rem_nxt = step_rsp.rem;
          acc_nxt = step_rsp.acc;
          cnt_nxt = cnt_r + 5'd1;
          if (phase_r == PH_MON) begin
            k_nxt = k_r + 4'd1;
          end
        end else begin
          // block size exhausted, move on
          cnt_nxt = '0;
          unique case (phase_r)
            PH_400: phase_nxt = PH_100;
            PH_100: begin
              q100_nxt  = cnt_r[1:0];
              phase_nxt = PH_4;
            end
            PH_4: begin
              q4_nxt    = cnt_r;
              phase_nxt = PH_1;
            end
            PH_1: begin
              q1_nxt    = cnt_r[1:0];
              k_nxt     = 4'd1;
              phase_nxt = PH_MON;
              if (to_serial) begin
                rem_nxt = {{(SW-4){1'b0}}, cur_m - 4'd1};
              end
            end
            default: phase_nxt = PH_DAY;
          endcase
        end
      end

      S_CMP: begin
        lt_nxt    = cmp_sub[SW];
        eq_nxt    = (s1_r == s2_r);
        gt_nxt    = !cmp_sub[SW] && (s1_r != s2_r);
        diff_nxt  = (mode_r == dga_pkg::MODE_DIFF) ? abs_diff : '0;
        state_nxt = S_ARITH;
      end

      S_ARITH: begin
        acc_nxt   = '0;
        phase_nxt = PH_400;
        cnt_nxt   = '0;
        ovf_nxt   = 1'b0;
        unique case (mode_r)
          dga_pkg::MODE_ADD: begin
            // past the last day saturates to the end of year 9999
            if (add_sum > {1'b0, dga_pkg::LAST_SERIAL}) begin
              rem_nxt = dga_pkg::LAST_SERIAL;
              ovf_nxt = 1'b1;
            end else begin
              rem_nxt = add_sum[SW-1:0];
            end
            state_nxt = S_CONV_R;
          end
          dga_pkg::MODE_SUB: begin
            // before the first day saturates to 0001-01-01
            if (sub_res[SW]) begin
              rem_nxt = '0;
              ovf_nxt = 1'b1;
            end else begin
              rem_nxt = sub_res[SW-1:0];
            end
            state_nxt = S_CONV_R;
          end
          default: begin
            // difference and undefined mode carry no date
            ry_nxt    = '0;
            rm_nxt    = '0;
            rd_nxt    = '0;
            state_nxt = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {7'b0, ovf_r, gt_r, eq_r, lt_r, diff_r, rd_r, rm_r, ry_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_400;
      cnt_r       <= '0;
      k_r         <= 4'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    acc_r      <= acc_nxt;
    q100_r     <= q100_nxt;
    q4_r       <= q4_nxt;
    q1_r       <= q1_nxt;
    mode_r     <= mode_nxt;
    y2_r       <= y2_nxt;
    m1_r       <= m1_nxt;
    m2_r       <= m2_nxt;
    d1_r       <= d1_nxt;
    d2_r       <= d2_nxt;
    dcnt_r     <= dcnt_nxt;
    s1_r       <= s1_nxt;
    s2_r       <= s2_nxt;
    ry_r       <= ry_nxt;
    rm_r       <= rm_nxt;
    rd_r       <= rd_nxt;
    diff_r     <= diff_nxt;
    lt_r       <= lt_nxt;
    eq_r       <= eq_nxt;
    gt_r       <= gt_nxt;
    ovf_r      <= ovf_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

### rtl/dga_checker.sv
// port-level checker for the gregorian date arithmetic block and its bind
`default_nettype none
module dga_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata
);

  // one request at a time: ready drops right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready still high after request taken");

  // exactly one comparison flag
  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot(out_tdata[47:45]))
    else $error("comparison flags not one-hot");

  // a nonzero distance result carries no date and no overflow
  a_diff_no_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[44:23] != 22'd0) |-> (out_tdata[22:0] == 23'd0) && !out_tdata[48])
    else $error("distance result with date fields");

  // overflow saturates to the first or last year
  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[48] |->
      (out_tdata[44:23] == 22'd0) &&
      ((out_tdata[13:0] == 14'd1) || (out_tdata[13:0] == 14'd9999)))
    else $error("overflow without saturated year");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind gregorian_date_arithmetic dga_checker u_dga_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
